// ===== src/radix_digit_emitter_defines.svh =====
// ----------------------------------------------------------------------------
// Radix digit emitter assertion macros
// Shared property forms for the checker of the radix digit emitter.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_EMITTER_DEFINES_SVH
`define RADIX_DIGIT_EMITTER_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define RDE_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define RDE_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/rde_pkg.sv =====
// ----------------------------------------------------------------------------
// Radix digit emitter package
// Widths, character codes, state types and digit helpers shared by the block.
// ----------------------------------------------------------------------------
package rde_pkg;

   localparam int FRAC_W     = 27;
   localparam int BASE_W     = 5;
   localparam int CHAR_W     = 7;
   localparam int DIGIT_W    = 4;
   localparam int PROD_W     = FRAC_W + DIGIT_W;
   localparam int FRAC_QBITS = 4;
   localparam int DIV_STEPS  = 8;
   localparam int STEP_W     = 3;

   localparam logic [FRAC_W-1:0]  FRAC_SCALE = 27'd100000000;
   localparam logic [FRAC_W-1:0]  FRAC_MAX   = 27'd99999999;
   localparam logic [BASE_W-1:0]  BASE_MIN   = 5'd2;
   localparam logic [BASE_W-1:0]  BASE_MAX   = 5'd16;
   localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;

   localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 7'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
   localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
   localparam logic [CHAR_W-1:0] CHAR_HEXF  = 7'h46;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_CALC,
      BK_EMIT
   } back_state_type;

   typedef enum logic [2:0] {
      KIND_SIGN,
      KIND_INT,
      KIND_DOT,
      KIND_FRAC,
      KIND_ERR
   } char_kind_type;

   typedef struct packed {
      logic bad;
      logic negative;
      logic frac_nz;
   } cmd_flags_type;

   function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
      if (d < DIGIT_TEN) begin
         return CHAR_ZERO + CHAR_W'(d);
      end else begin
         return CHAR_UPPER + CHAR_W'(d - DIGIT_TEN);
      end
   endfunction

   // Divisor for one restoring step of a fraction digit: the scale shifted
   // to the weight of the quotient bit that the step decides.
   function automatic logic [PROD_W-1:0] frac_divisor(input logic [STEP_W-1:0] step);
      logic [PROD_W-1:0] s;
      s = PROD_W'(FRAC_SCALE);
      case (step)
         3'd1:    return s << 3;
         3'd2:    return s << 2;
         3'd3:    return s << 1;
         default: return s;
      endcase
   endfunction

endpackage

// ===== src/rde_if.sv =====
// ----------------------------------------------------------------------------
// Radix digit emitter channel interfaces
// Valid/ready channels for the number items and the character results.
// ----------------------------------------------------------------------------
interface rde_req_if #(parameter int INT_BITS = 31);
   import rde_pkg::*;

   logic                valid;
   logic                ready;
   logic                negative;
   logic [INT_BITS-1:0] int_part;
   logic [FRAC_W-1:0]   frac_units;
   logic [BASE_W-1:0]   base;

   modport source (output valid, negative, int_part, frac_units, base, input ready);
   modport sink   (input valid, negative, int_part, frac_units, base, output ready);
endinterface

interface rde_rsp_if;
   import rde_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              last;
   logic              error;

   modport source (output valid, char_code, last, error, input ready);
   modport sink   (input valid, char_code, last, error, output ready);
endinterface

// ===== src/rde_ram.sv =====
// ----------------------------------------------------------------------------
// Radix digit emitter generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/rde_fifo.sv =====
// ----------------------------------------------------------------------------
// Radix digit emitter command queue
// Small valid/ready queue between the classifying front and the back end.
// ----------------------------------------------------------------------------
module rde_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// ===== src/rde_front.sv =====
// ----------------------------------------------------------------------------
// Radix digit emitter front end
// Takes number items, checks the base, clamps the fraction and queues a command.
// ----------------------------------------------------------------------------
module rde_front #(
   parameter int INT_BITS = 31
) (
   rde_req_if.sink req,
   output logic                                   push_valid,
   input  logic                                   push_ready,
   output logic [$bits(rde_pkg::cmd_flags_type) + rde_pkg::FRAC_W
                 + rde_pkg::BASE_W + INT_BITS - 1:0] push_data
);
   import rde_pkg::*;

   cmd_flags_type     flags;
   logic [FRAC_W-1:0] frac_sat;

   always_comb begin
      frac_sat       = (req.frac_units > FRAC_MAX) ? FRAC_MAX : req.frac_units;
      flags.bad      = (req.base < BASE_MIN) || (req.base > BASE_MAX);
      flags.negative = req.negative;
      flags.frac_nz  = (frac_sat != '0);
   end

   assign push_valid = req.valid;
   assign req.ready  = push_ready;
   assign push_data  = {flags, frac_sat, req.base, req.int_part};
endmodule

// ===== src/rde_back.sv =====
// ----------------------------------------------------------------------------
// Radix digit emitter back end
// Divides out the integer and fraction digits, then streams the characters.
// ----------------------------------------------------------------------------
module rde_back #(
   parameter int INT_BITS    = 31,
   parameter int FRAC_DIGITS = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic                                   cmd_valid,
   output logic                                   cmd_ready,
   input  logic [$bits(rde_pkg::cmd_flags_type) + rde_pkg::FRAC_W
                 + rde_pkg::BASE_W + INT_BITS - 1:0] cmd_data,
   rde_rsp_if.source rsp
);
   import rde_pkg::*;

   localparam int FLAG_W  = $bits(cmd_flags_type);
   localparam int CMD_W   = FLAG_W + FRAC_W + BASE_W + INT_BITS;
   localparam int DIV_CYC = (INT_BITS + DIV_STEPS - 1) / DIV_STEPS;
   localparam int DIV_W   = DIV_CYC * DIV_STEPS;
   localparam int CNT_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
   localparam int AW      = $clog2(INT_BITS);
   localparam int NW      = $clog2(INT_BITS + 1);
   localparam int FIW     = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;
   localparam int FNW     = $clog2(FRAC_DIGITS + 1);

   // Command fields
   cmd_flags_type       cmd_flags;
   logic [FRAC_W-1:0]   cmd_frac;
   logic [BASE_W-1:0]   cmd_base;
   logic [INT_BITS-1:0] cmd_int;

   assign cmd_flags = cmd_flags_type'(cmd_data[CMD_W-1 -: FLAG_W]);
   assign cmd_frac  = cmd_data[CMD_W-FLAG_W-1 -: FRAC_W];
   assign cmd_base  = cmd_data[INT_BITS+BASE_W-1 -: BASE_W];
   assign cmd_int   = cmd_data[INT_BITS-1:0];

   back_state_type state_ff, state_in;

   logic                dot_ff, dot_in;
   logic [BASE_W-1:0]   base_ff, base_in;

   // Integer divider
   logic [DIV_W-1:0]    ip_ff, ip_in;
   logic [DIGIT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [NW-1:0]       wp_ff, wp_in;
   logic                idone_ff, idone_in;
   logic [DIV_W-1:0]    div_q;
   logic [DIGIT_W:0]    div_r;

   // Fraction digit unit
   logic [FRAC_W-1:0]   fr_ff, fr_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [DIGIT_W-1:0]  dq_ff, dq_in;
   logic [STEP_W-1:0]   fstep_ff, fstep_in;
   logic [FNW-1:0]      fi_ff, fi_in;
   logic [FNW-1:0]      flen_ff, flen_in;
   logic                fdone_ff, fdone_in;
   logic [DIGIT_W-1:0]  fd_ff [FRAC_DIGITS];
   logic [DIGIT_W-1:0]  fd_in [FRAC_DIGITS];
   logic [PROD_W-1:0]   fdiv;
   logic                fge;
   logic [DIGIT_W-1:0]  dq_next;
   logic [PROD_W-1:0]   prod_sub;

   // Character generator and pending stage
   char_kind_type       gk_ff, gk_in;
   logic [FNW-1:0]      fe_ff, fe_in;
   logic                gen_valid;
   logic                gen_last;
   logic                p_valid_ff, p_valid_in;
   char_kind_type       p_kind_ff, p_kind_in;
   logic [DIGIT_W-1:0]  p_dig_ff, p_dig_in;
   logic                p_last_ff, p_last_in;
   logic                p_load;
   logic                out_load;
   logic                calc_en;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic                last_ff, last_in;
   logic                err_ff, err_in;
   logic [CHAR_W-1:0]   p_char;

   // Digit stack
   logic                ram_wr_en;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [DIGIT_W-1:0]  ram_rd_data;

   rde_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (INT_BITS)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff[AW-1:0]),
      .wr_data (div_r[DIGIT_W-1:0]),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               state_in = cmd_flags.bad ? BK_EMIT : BK_CALC;
            end
         end
         BK_CALC: begin
            if (idone_ff && fdone_ff) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (p_load && gen_last) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      cmd_ready = 1'b0;
      calc_en   = 1'b0;
      gen_valid = 1'b0;
      unique case (state_ff)
         BK_IDLE: cmd_ready = 1'b1;
         BK_CALC: calc_en   = 1'b1;
         BK_EMIT: gen_valid = 1'b1;
         default: cmd_ready = 1'b0;
      endcase
   end

   // Eight restoring steps of the integer division per cycle; the partial
   // remainder stays below twice the base, so it fits in five bits.
   always_comb begin
      div_q = ip_ff;
      div_r = {1'b0, rem_ff};
      for (int k = 0; k < DIV_STEPS; k++) begin
         div_r = {div_r[DIGIT_W-1:0], div_q[DIV_W-1]};
         div_q = {div_q[DIV_W-2:0], 1'b0};
         if (div_r >= base_ff) begin
            div_r    = div_r - base_ff;
            div_q[0] = 1'b1;
         end
      end
   end

   // One quotient bit of a fraction digit per cycle.
   always_comb begin
      fdiv     = frac_divisor(fstep_ff);
      fge      = (prod_ff >= fdiv);
      dq_next  = {dq_ff[DIGIT_W-2:0], fge};
      prod_sub = fge ? prod_ff - fdiv : prod_ff;
   end

   // Whether the character about to enter the pending stage ends the text.
   always_comb begin
      case (gk_ff)
         KIND_SIGN: gen_last = 1'b0;
         KIND_INT:  gen_last = (wp_ff == NW'(1)) && !dot_ff;
         KIND_DOT:  gen_last = (flen_ff == '0);
         KIND_FRAC: gen_last = (fe_ff == flen_ff - 1'b1);
         KIND_ERR:  gen_last = 1'b1;
         default:   gen_last = 1'b1;
      endcase
   end

   assign out_load    = p_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign p_load      = gen_valid && (!p_valid_ff || out_load);
   assign ram_rd_en   = p_load && (gk_ff == KIND_INT);
   assign ram_rd_addr = AW'(wp_ff - 1'b1);
   assign ram_wr_en   = calc_en && !idone_ff && (cnt_ff == CNT_W'(DIV_CYC - 1));

   always_comb begin
      case (p_kind_ff)
         KIND_SIGN: p_char = CHAR_MINUS;
         KIND_INT:  p_char = digit_glyph(ram_rd_data);
         KIND_DOT:  p_char = CHAR_DOT;
         KIND_FRAC: p_char = digit_glyph(p_dig_ff);
         default:   p_char = CHAR_NONE;
      endcase
   end

   // Datapath next values
   always_comb begin
      dot_in       = dot_ff;
      base_in      = base_ff;
      ip_in        = ip_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      wp_in        = wp_ff;
      idone_in     = idone_ff;
      fr_in        = fr_ff;
      prod_in      = prod_ff;
      dq_in        = dq_ff;
      fstep_in     = fstep_ff;
      fi_in        = fi_ff;
      flen_in      = flen_ff;
      fdone_in     = fdone_ff;
      fd_in        = fd_ff;
      gk_in        = gk_ff;
      fe_in        = fe_ff;
      p_valid_in   = p_valid_ff;
      p_kind_in    = p_kind_ff;
      p_dig_in     = p_dig_ff;
      p_last_in    = p_last_ff;
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      err_in       = err_ff;

      if (cmd_ready && cmd_valid) begin
         dot_in   = cmd_flags.frac_nz;
         base_in  = cmd_base;
         ip_in    = DIV_W'(cmd_int);
         rem_in   = '0;
         cnt_in   = '0;
         wp_in    = '0;
         idone_in = 1'b0;
         fr_in    = cmd_frac;
         fstep_in = '0;
         fi_in    = '0;
         flen_in  = '0;
         fdone_in = !cmd_flags.frac_nz;
         fe_in    = '0;
         if (cmd_flags.bad) begin
            gk_in = KIND_ERR;
         end else if (cmd_flags.negative) begin
            gk_in = KIND_SIGN;
         end else begin
            gk_in = KIND_INT;
         end
      end

      if (calc_en && !idone_ff) begin
         ip_in = div_q;
         if (cnt_ff == CNT_W'(DIV_CYC - 1)) begin
            rem_in   = '0;
            cnt_in   = '0;
            wp_in    = wp_ff + 1'b1;
            idone_in = (div_q == '0);
         end else begin
            rem_in = div_r[DIGIT_W-1:0];
            cnt_in = cnt_ff + 1'b1;
         end
      end

      if (calc_en && !fdone_ff) begin
         if (fstep_ff == '0) begin
            prod_in  = {{(PROD_W - FRAC_W){1'b0}}, fr_ff}
                       * {{(PROD_W - BASE_W){1'b0}}, base_ff};
            dq_in    = '0;
            fstep_in = fstep_ff + 1'b1;
         end else begin
            prod_in = prod_sub;
            dq_in   = dq_next;
            if (fstep_ff == STEP_W'(FRAC_QBITS)) begin
               fr_in              = prod_sub[FRAC_W-1:0];
               fd_in[fi_ff[FIW-1:0]] = dq_next;
               if (dq_next != '0) begin
                  flen_in = fi_ff + 1'b1;
               end
               fi_in    = fi_ff + 1'b1;
               fdone_in = (fi_ff == FNW'(FRAC_DIGITS - 1));
               fstep_in = '0;
            end else begin
               fstep_in = fstep_ff + 1'b1;
            end
         end
      end

      if (p_load) begin
         p_kind_in = gk_ff;
         p_dig_in  = fd_ff[fe_ff[FIW-1:0]];
         p_last_in = gen_last;
         case (gk_ff)
            KIND_SIGN: gk_in = KIND_INT;
            KIND_INT: begin
               wp_in = wp_ff - 1'b1;
               if (wp_ff == NW'(1)) begin
                  gk_in = KIND_DOT;
               end
            end
            KIND_DOT:  gk_in = KIND_FRAC;
            KIND_FRAC: fe_in = fe_ff + 1'b1;
            default:   gk_in = gk_ff;
         endcase
      end

      if (p_load) begin
         p_valid_in = 1'b1;
      end else if (out_load) begin
         p_valid_in = 1'b0;
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
         char_in      = p_char;
         last_in      = p_last_ff;
         err_in       = (p_kind_ff == KIND_ERR);
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dot_ff    <= dot_in;
      base_ff   <= base_in;
      ip_ff     <= ip_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      wp_ff     <= wp_in;
      idone_ff  <= idone_in;
      fr_ff     <= fr_in;
      prod_ff   <= prod_in;
      dq_ff     <= dq_in;
      fstep_ff  <= fstep_in;
      fi_ff     <= fi_in;
      flen_ff   <= flen_in;
      fdone_ff  <= fdone_in;
      fd_ff     <= fd_in;
      gk_ff     <= gk_in;
      fe_ff     <= fe_in;
      p_kind_ff <= p_kind_in;
      p_dig_ff  <= p_dig_in;
      p_last_ff <= p_last_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
      err_ff    <= err_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.char_code = char_ff;
   assign rsp.last      = last_ff;
   assign rsp.error     = err_ff;
endmodule

// ===== src/radix_digit_emitter.sv =====
// ----------------------------------------------------------------------------
// Radix digit emitter
// Turns a signed fixed-point number into its ASCII text in base 2 to 16.
//
//   Channel  Dir  Handshake          Payload
//   req      in   req.valid/ready    negative, int_part, frac_units, base
//   rsp      out  rsp.valid/ready    char_code, last, error
//
// The integer is divided by the base eight quotient bits a cycle; in parallel
// each fraction digit is found by one multiply and four restoring steps.
// Once the calculation is done, the characters are streamed out through a
// pending stage and an output register.
// A bad base skips the calculation and gives one error transfer.
// Reset is synchronous; a stalled rsp holds its character while the queue
// keeps taking up to two further items.
// ----------------------------------------------------------------------------
module radix_digit_emitter #(
   parameter int INT_BITS    = 31,
   parameter int FRAC_DIGITS = 4
) (
   input logic clock,
   input logic reset,
   rde_req_if.sink   req,
   rde_rsp_if.source rsp
);
   import rde_pkg::*;

   localparam int CMD_W = $bits(cmd_flags_type) + FRAC_W + BASE_W + INT_BITS;

   logic             push_valid;
   logic             push_ready;
   logic [CMD_W-1:0] push_data;
   logic             pop_valid;
   logic             pop_ready;
   logic [CMD_W-1:0] pop_data;

   rde_front #(
      .INT_BITS (INT_BITS)
   ) u_front (
      .req        (req),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   rde_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (2)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rde_back #(
      .INT_BITS    (INT_BITS),
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cmd_data  (pop_data),
      .rsp       (rsp)
   );
endmodule

// ===== src/rde_checker.sv =====
// ----------------------------------------------------------------------------
// Radix digit emitter checker
// Watches the result channel for well-formed text and error transfers.
// ----------------------------------------------------------------------------
`include "radix_digit_emitter_defines.svh"

module rde_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [rde_pkg::CHAR_W-1:0] rsp_char_code,
   input logic                      rsp_last,
   input logic                      rsp_error
);
   import rde_pkg::*;

   logic in_text_ff, in_text_in;
   logic legal_char;

   // High while a number's text has started but its last character is not out.
   always_comb begin
      in_text_in = in_text_ff;
      if (rsp_valid && rsp_ready) begin
         in_text_in = !rsp_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_text_ff <= 1'b0;
      end else begin
         in_text_ff <= in_text_in;
      end
   end

   assign legal_char = ((rsp_char_code >= CHAR_ZERO) && (rsp_char_code <= CHAR_NINE))
                    || ((rsp_char_code >= CHAR_UPPER) && (rsp_char_code <= CHAR_HEXF))
                    || (rsp_char_code == CHAR_MINUS) || (rsp_char_code == CHAR_DOT);

   `RDE_ASSERT_IMP(a_error_alone, rsp_valid && rsp_error,
                   rsp_last && (rsp_char_code == CHAR_NONE) && !in_text_ff,
                   "error result is not a lone final transfer")

   `RDE_ASSERT_IMP(a_char_legal, rsp_valid && !rsp_error, legal_char,
                   "character outside the digit, sign and point set")

   `RDE_ASSERT_IMP(a_sign_first, rsp_valid && (rsp_char_code == CHAR_MINUS),
                   !in_text_ff && !rsp_last,
                   "minus sign not at the start of a number")

   `RDE_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready,
                   rsp_valid && $stable(rsp_char_code) && $stable(rsp_last),
                   "stalled result changed")
endmodule

bind radix_digit_emitter rde_checker u_rde_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_char_code (rsp.char_code),
   .rsp_last      (rsp.last),
   .rsp_error     (rsp.error)
);
